>>> rtl/abr_pkg.sv
// abr_pkg: shared types and codes for the bubble adaptive route compute unit
// holds port and channel codes, the candidate list entry and queue status
// no dependencies
package abr_pkg;

    // output port codes
    localparam logic [2:0] PORT_LOCAL = 3'd0;
    localparam logic [2:0] PORT_XP    = 3'd1;
    localparam logic [2:0] PORT_XM    = 3'd2;
    localparam logic [2:0] PORT_YP    = 3'd3;
    localparam logic [2:0] PORT_YM    = 3'd4;

    // virtual channel codes
    localparam logic [2:0] CH_ADAPT     = 3'd1;
    localparam logic [2:0] CH_DOR_REPLY = 3'd2;
    localparam logic [2:0] CH_DOR_REQ   = 3'd3;

    // input channel value that marks an adaptive channel
    localparam logic [1:0] IN_CH_ADAPT = 2'd1;

    // configuration register indexes
    localparam logic CFG_MISROUTE_EN = 1'b0;
    localparam logic CFG_LOCAL_PORT  = 1'b1;

    // result tuser bit positions
    localparam int M_TUSER_EMPTY = 0;
    localparam int M_TUSER_ERROR = 1;

    localparam int MAX_CANDS = 4;

    // one candidate pair
    typedef struct packed {
        logic [2:0] chan;
        logic [2:0] port;
    } cand_t;

    // classified header: full candidate list ready for the back end
    typedef struct packed {
        cand_t [MAX_CANDS-1:0] cand;
        logic [1:0]            last_idx;
        logic                  list_empty;
        logic                  route_error;
    } route_list_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/abr_front.sv
// abr_front: accepts headers and classifies them into a candidate list
// depends on abr_pkg; feeds abr_queue
module abr_front #(
    parameter int OFFSET_BITS = 7
) (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [OFFSET_BITS-1:0]   offset_x,
    input  logic [OFFSET_BITS-1:0]   offset_y,
    input  logic                     misroute_x,
    input  logic                     misroute_y,
    input  logic                     is_request,
    input  logic                     last_misrouted,
    input  logic [2:0]               in_direction,
    input  logic [1:0]               in_channel,
    input  logic [7:0]               bubble_ready,
    input  logic [2:0]               random_bits,
    input  logic                     misroute_enable,
    input  logic [2:0]               local_port_number,
    input  abr_pkg::q_status_t       q_status,
    output logic                     push,
    output abr_pkg::route_list_t     list_o
);

    logic [OFFSET_BITS-1:0] ax, ay, thr;
    logic gtx, gty, eqx, eqy, zx, zy;
    logic [2:0] px, py;

    // accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // magnitudes and threshold compares
    assign ax  = offset_x[OFFSET_BITS-1] ? (~offset_x + 1'b1) : offset_x;
    assign ay  = offset_y[OFFSET_BITS-1] ? (~offset_y + 1'b1) : offset_y;
    assign thr = {{(OFFSET_BITS-1){1'b0}}, ~misroute_enable};
    assign gtx = ax > thr;
    assign gty = ay > thr;
    assign eqx = ax == thr;
    assign eqy = ay == thr;
    assign zx  = ax == '0;
    assign zy  = ay == '0;
    assign px  = (!offset_x[OFFSET_BITS-1] && !zx) ? abr_pkg::PORT_XP : abr_pkg::PORT_XM;
    assign py  = (!offset_y[OFFSET_BITS-1] && !zy) ? abr_pkg::PORT_YP : abr_pkg::PORT_YM;

    // build the ordered candidate list
    always_comb begin : classify
        logic [2:0] n;
        logic       dir_x, dir_y, xfirst, have, ok, err, chk, y_mis_first;
        logic [2:0] np, dor_ch;
        logic [3:0] bub_sel;
        logic [1:0] bidx;
        logic       do_y, flag, az, plus_first;
        logic [2:0] pp, pm;

        list_o  = '0;
        n       = 3'd0;
        dir_x   = (in_direction == abr_pkg::PORT_XP) || (in_direction == abr_pkg::PORT_XM);
        dir_y   = (in_direction == abr_pkg::PORT_YP) || (in_direction == abr_pkg::PORT_YM);
        dor_ch  = is_request ? abr_pkg::CH_DOR_REQ : abr_pkg::CH_DOR_REPLY;
        bub_sel = is_request ? bubble_ready[3:0] : bubble_ready[7:4];
        err     = 1'b0;
        ok      = 1'b0;
        chk     = 1'b0;

        // adaptive channels
        xfirst = last_misrouted ? dir_y : random_bits[0];
        if (xfirst) begin
            if (gtx) begin
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: px};
                n = n + 3'd1;
            end
            if (gty) begin
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: py};
                n = n + 3'd1;
            end
        end else begin
            if (gty) begin
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: py};
                n = n + 3'd1;
            end
            if (gtx) begin
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: px};
                n = n + 3'd1;
            end
        end

        // dimension-order candidate under the bubble condition
        have = gtx || (eqx && gty);
        np   = gtx ? px : py;
        if (have) begin
            if (in_direction == abr_pkg::PORT_LOCAL || in_channel == abr_pkg::IN_CH_ADAPT) begin
                chk = 1'b1;
            end else if (in_direction == np) begin
                ok = 1'b1;
            end else if (np == abr_pkg::PORT_XP || np == abr_pkg::PORT_XM) begin
                err = 1'b1;
            end else begin
                chk = 1'b1;
            end
        end
        bidx = 2'(np - 3'd1);
        if (chk) begin
            ok = bub_sel[bidx];
        end
        if (ok) begin
            list_o.cand[n[1:0]] = '{chan: dor_ch, port: np};
            n = n + 3'd1;
        end

        // misroute pairs
        y_mis_first = dir_x || (in_direction == abr_pkg::PORT_LOCAL);
        for (int i = 0; i < 2; i++) begin
            do_y       = y_mis_first ? (i == 0) : (i == 1);
            flag       = do_y ? misroute_y : misroute_x;
            az         = do_y ? zy : zx;
            plus_first = do_y ? random_bits[1] : random_bits[2];
            pp         = do_y ? abr_pkg::PORT_YP : abr_pkg::PORT_XP;
            pm         = do_y ? abr_pkg::PORT_YM : abr_pkg::PORT_XM;
            if (flag && az && n <= 3'd2) begin
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: plus_first ? pp : pm};
                n = n + 3'd1;
                list_o.cand[n[1:0]] = '{chan: abr_pkg::CH_ADAPT, port: plus_first ? pm : pp};
                n = n + 3'd1;
            end
        end

        // arrival, forbidden turn and empty list each give a lone result
        if (eqx && eqy) begin
            list_o = '0;
            list_o.cand[0] = '{chan: local_port_number, port: abr_pkg::PORT_LOCAL};
        end else if (err) begin
            list_o = '0;
            list_o.route_error = 1'b1;
            list_o.list_empty  = 1'b1;
        end else if (n == 3'd0) begin
            list_o = '0;
            list_o.list_empty = 1'b1;
        end else begin
            list_o.last_idx = 2'(n - 3'd1);
        end
    end

endmodule

>>> rtl/abr_queue.sv
// abr_queue: two-entry queue of classified candidate lists
// depends on abr_pkg; sits between abr_front and abr_back
module abr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  abr_pkg::route_list_t  push_data,
    input  logic                  pop,
    output abr_pkg::route_list_t  head,
    output abr_pkg::q_status_t    status
);

    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    abr_pkg::route_list_t mem [2];

    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;
    assign head         = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/abr_back.sv
// abr_back: walks the queue head list and sends one candidate per transfer
// depends on abr_pkg; reads abr_queue, drives the result channel register
module abr_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  abr_pkg::route_list_t  head,
    input  abr_pkg::q_status_t    q_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic [1:0]     idx_reg, idx_next;
    logic           m_tvalid_reg, m_tvalid_next;
    abr_pkg::cand_t cand_reg, cand_next;
    logic [1:0]     user_reg, user_next;
    logic           last_reg, last_next;
    logic           load, fire, is_last;

    // output register loads when empty or being drained
    assign load    = !m_tvalid_reg || m_tready;
    assign fire    = load && !q_status.empty;
    assign is_last = idx_reg == head.last_idx;
    assign pop     = fire && is_last;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        cand_next     = cand_reg;
        user_next     = user_reg;
        last_next     = last_reg;
        if (load) begin
            m_tvalid_next = fire;
        end
        if (fire) begin
            cand_next = head.cand[idx_reg];
            user_next[abr_pkg::M_TUSER_EMPTY] = head.list_empty;
            user_next[abr_pkg::M_TUSER_ERROR] = head.route_error;
            last_next = is_last;
            idx_next  = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, cand_reg.chan, cand_reg.port};
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/bubble_adaptive_route_compute_unit.sv
// bubble_adaptive_route_compute_unit: route computation for a 2D torus router input
// top level; instantiates abr_front, abr_queue and abr_back, uses abr_pkg
//
// Usage:
//   A header enters on the s_ channel; each candidate (port, channel) pair
//   leaves as one transfer on the m_ channel, m_tlast on the final one.
//   Arrival, an empty list and a forbidden X turn each give one lone
//   transfer with the flags in m_tuser.
//   Configuration: cfg_we/cfg_index/cfg_wdata write misroute_enable (0)
//   or local_port_number (1), taken on any edge with cfg_we high out of reset.
// Path: headers go into the list queue; results leave from the output register.
// Throughput: a header has 1 to 4 results; while m_tready is high,
//   the back end sends one candidate per cycle from the queue head.
//   The front end classifies a header combinationally and takes a new one
//   every cycle while the two-entry list queue has room.
// Reset: aresetn low clears the queue, output valid and both registers.
// Stall: with m_tready low the result holds; the queue fills and then
//   s_tready drops.
module bubble_adaptive_route_compute_unit #(
    parameter int OFFSET_BITS = 7
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // offset_x, offset_y, misroute_x, misroute_y, last_misrouted,
    // in_direction, in_channel, bubble_ready, random_bits, zero fill
    input  logic [((2*OFFSET_BITS+19+7)/8)*8-1:0] s_tdata,
    // is_request
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_port, out_channel, zero fill
    output logic [7:0] m_tdata,
    // list_empty, route_error
    output logic [1:0] m_tuser,
    output logic m_tlast,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [2:0] cfg_wdata
);

    localparam int OB = OFFSET_BITS;
    localparam int MX_POS  = 2*OB;
    localparam int MY_POS  = 2*OB + 1;
    localparam int LM_POS  = 2*OB + 2;
    localparam int DIR_POS = 2*OB + 3;
    localparam int CH_POS  = 2*OB + 6;
    localparam int BUB_POS = 2*OB + 8;
    localparam int RND_POS = 2*OB + 16;

    logic                 misroute_enable_reg;
    logic [2:0]           local_port_number_reg;
    abr_pkg::q_status_t   q_status;
    abr_pkg::route_list_t list_in, list_head;
    logic                 push, pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            misroute_enable_reg   <= 1'b0;
            local_port_number_reg <= 3'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                abr_pkg::CFG_MISROUTE_EN: misroute_enable_reg   <= cfg_wdata[0];
                abr_pkg::CFG_LOCAL_PORT:  local_port_number_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    abr_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .offset_x          (s_tdata[OB-1:0]),
        .offset_y          (s_tdata[2*OB-1:OB]),
        .misroute_x        (s_tdata[MX_POS]),
        .misroute_y        (s_tdata[MY_POS]),
        .is_request        (s_tuser),
        .last_misrouted    (s_tdata[LM_POS]),
        .in_direction      (s_tdata[DIR_POS+2:DIR_POS]),
        .in_channel        (s_tdata[CH_POS+1:CH_POS]),
        .bubble_ready      (s_tdata[BUB_POS+7:BUB_POS]),
        .random_bits       (s_tdata[RND_POS+2:RND_POS]),
        .misroute_enable   (misroute_enable_reg),
        .local_port_number (local_port_number_reg),
        .q_status          (q_status),
        .push              (push),
        .list_o            (list_in)
    );

    abr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (list_in),
        .pop       (pop),
        .head      (list_head),
        .status    (q_status)
    );

    abr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (list_head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/abr_checker.sv
// abr_checker: port-level assertions on the result channel
// depends on abr_pkg; bound to bubble_adaptive_route_compute_unit
module abr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // nothing valid right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled transfer holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // error result is a lone empty transfer with zero payload
    a_error_lone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[abr_pkg::M_TUSER_ERROR] |->
            m_tuser[abr_pkg::M_TUSER_EMPTY] && m_tlast && m_tdata == 8'd0)
        else $error("bad error result");

    // empty list result closes the list on the local code
    a_empty_lone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[abr_pkg::M_TUSER_EMPTY] |->
            m_tlast && m_tdata[2:0] == abr_pkg::PORT_LOCAL)
        else $error("bad empty result");

    // local port and the m_tuser flags only appear on the final candidate
    a_local_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[2:0] != abr_pkg::PORT_LOCAL
            && m_tuser == 2'b00)
        else $error("local or flagged result inside a list");

endmodule

bind bubble_adaptive_route_compute_unit abr_checker u_abr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/bubble_adaptive_route_compute_unit_tb.sv
// bubble_adaptive_route_compute_unit_tb: self-checking testbench for the route compute unit
// streams headers through the s_ side, predicts each candidate list and checks the m_ side
// depends on abr_pkg and bubble_adaptive_route_compute_unit
module bubble_adaptive_route_compute_unit_tb;

    localparam int OFFSET_BITS = 7;
    localparam int S_DATA_W    = ((2*OFFSET_BITS+19+7)/8)*8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PRINT_LIMIT = 40;
    localparam int HOLD_CYCLES = 80;

    // in_direction values outside the five ports
    localparam logic [2:0] DIR_UNUSED_LO = 3'd5;
    localparam logic [2:0] DIR_UNUSED_HI = 3'd7;

    // one header as seen on the s_ side
    typedef struct {
        logic signed [OFFSET_BITS-1:0] off_x;
        logic signed [OFFSET_BITS-1:0] off_y;
        logic       mis_x;
        logic       mis_y;
        logic       is_req;
        logic       last_mis;
        logic [2:0] in_dir;
        logic [1:0] in_ch;
        logic [7:0] bubble;
        logic [2:0] rnd;
    } header_t;

    // one candidate as seen on the m_ side
    typedef struct {
        logic [2:0] port;
        logic [2:0] chan;
        logic       empty;
        logic       err;
        logic       last;
    } cand_res_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic cfg_index = abr_pkg::CFG_MISROUTE_EN;
    logic [2:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic       cfg_misroute_en = 1'b0;
    logic [2:0] cfg_local_port  = 3'd0;

    header_t   hdr_queue[$];
    cand_res_t expected_cands[$];
    header_t   cur_hdr;
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;

    bubble_adaptive_route_compute_unit #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_cand(input logic [2:0] port, input logic [2:0] chan,
                                      input logic empty, input logic err, input logic last);
        cand_res_t c;
        c.port  = port;
        c.chan  = chan;
        c.empty = empty;
        c.err   = err;
        c.last  = last;
        expected_cands.push_back(c);
    endfunction

    // candidate list for one header under the current register values
    function automatic void predict_route(input header_t h);
        int thr, dx, dy, ax, ay, n, k, a;
        logic [2:0] bitpos;
        logic [2:0] px, py, dor_ch, np, pp, pm;
        logic [2:0] ports[4];
        logic [2:0] chans[4];
        logic dir_x, dir_y, x_first, use_x, have_dor, ok, do_y, flag, plus_first;
        thr = cfg_misroute_en ? 0 : 1;
        dx = h.off_x;
        dy = h.off_y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        px = (dx > 0) ? abr_pkg::PORT_XP : abr_pkg::PORT_XM;
        py = (dy > 0) ? abr_pkg::PORT_YP : abr_pkg::PORT_YM;
        dor_ch = h.is_req ? abr_pkg::CH_DOR_REQ : abr_pkg::CH_DOR_REPLY;
        dir_x = (h.in_dir == abr_pkg::PORT_XP) || (h.in_dir == abr_pkg::PORT_XM);
        dir_y = (h.in_dir == abr_pkg::PORT_YP) || (h.in_dir == abr_pkg::PORT_YM);
        n = 0;

        // arrived: lone local result
        if (ax == thr && ay == thr) begin
            push_cand(abr_pkg::PORT_LOCAL, cfg_local_port, 1'b0, 1'b0, 1'b1);
            return;
        end

        // adaptive candidates
        x_first = h.last_mis ? dir_y : h.rnd[0];
        for (k = 0; k < 2; k++) begin
            use_x = ((k == 0) == x_first);
            if (use_x && ax > thr) begin
                ports[n] = px;
                chans[n] = abr_pkg::CH_ADAPT;
                n++;
            end else if (!use_x && ay > thr) begin
                ports[n] = py;
                chans[n] = abr_pkg::CH_ADAPT;
                n++;
            end
        end

        // dimension-order candidate and its bubble condition
        have_dor = 1'b0;
        np = abr_pkg::PORT_LOCAL;
        if (ax > thr) begin
            np = px;
            have_dor = 1'b1;
        end else if (ax == thr && ay > thr) begin
            np = py;
            have_dor = 1'b1;
        end
        if (have_dor) begin
            bitpos = 3'(int'(np) - 1 + (h.is_req ? 0 : 4));
            if (h.in_dir == abr_pkg::PORT_LOCAL || h.in_ch == abr_pkg::IN_CH_ADAPT) begin
                ok = h.bubble[bitpos];
            end else if (h.in_dir == np) begin
                ok = 1'b1;
            end else if (np == abr_pkg::PORT_XP || np == abr_pkg::PORT_XM) begin
                // dor to dor turn into x is not allowed
                push_cand(abr_pkg::PORT_LOCAL, 3'd0, 1'b1, 1'b1, 1'b1);
                return;
            end else begin
                ok = h.bubble[bitpos];
            end
            if (ok) begin
                ports[n] = np;
                chans[n] = dor_ch;
                n++;
            end
        end

        // misroute pairs, y first when entering from x or local
        for (k = 0; k < 2; k++) begin
            do_y = (dir_x || h.in_dir == abr_pkg::PORT_LOCAL) ? (k == 0) : (k == 1);
            flag = do_y ? h.mis_y : h.mis_x;
            a = do_y ? ay : ax;
            plus_first = do_y ? h.rnd[1] : h.rnd[2];
            pp = do_y ? abr_pkg::PORT_YP : abr_pkg::PORT_XP;
            pm = do_y ? abr_pkg::PORT_YM : abr_pkg::PORT_XM;
            if (flag && a == 0 && n <= 2) begin
                ports[n] = plus_first ? pp : pm;
                chans[n] = abr_pkg::CH_ADAPT;
                ports[n+1] = plus_first ? pm : pp;
                chans[n+1] = abr_pkg::CH_ADAPT;
                n += 2;
            end
        end

        if (n == 0) begin
            push_cand(abr_pkg::PORT_LOCAL, 3'd0, 1'b1, 1'b0, 1'b1);
            return;
        end
        for (k = 0; k < n; k++)
            push_cand(ports[k], chans[k], 1'b0, 1'b0, k == n - 1);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_header(input header_t h);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[2*OFFSET_BITS+18:0] = {h.rnd, h.bubble, h.in_ch, h.in_dir, h.last_mis,
                                 h.mis_y, h.mis_x, h.off_y, h.off_x};
        return d;
    endfunction

    function automatic header_t mk_header(input int ox, input int oy, input logic mx,
                                          input logic my, input logic req, input logic lm,
                                          input logic [2:0] dir, input logic [1:0] ch,
                                          input logic [7:0] bub, input logic [2:0] rnd);
        header_t h;
        h.off_x    = OFFSET_BITS'(ox);
        h.off_y    = OFFSET_BITS'(oy);
        h.mis_x    = mx;
        h.mis_y    = my;
        h.is_req   = req;
        h.last_mis = lm;
        h.in_dir   = dir;
        h.in_ch    = ch;
        h.bubble   = bub;
        h.rnd      = rnd;
        return h;
    endfunction

    // offsets cluster around the arrival threshold, with some from -32 to 32 and extremes
    function automatic int pick_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return int'($urandom_range(0, 4)) - 2;
        else if (r < 8)
            return int'($urandom_range(0, 64)) - 32;
        case ($urandom_range(0, 3))
            0: return 32;
            1: return -32;
            2: return 31;
            default: return -31;
        endcase
    endfunction

    task automatic add_random(input int count);
        header_t h;
        int k;
        for (k = 0; k < count; k++) begin
            h.off_x    = OFFSET_BITS'(pick_offset());
            h.off_y    = OFFSET_BITS'(pick_offset());
            h.mis_x    = 1'($urandom_range(0, 1));
            h.mis_y    = 1'($urandom_range(0, 1));
            h.is_req   = 1'($urandom_range(0, 1));
            h.last_mis = 1'($urandom_range(0, 1));
            h.in_dir   = ($urandom_range(0, 19) == 0)
                         ? 3'($urandom_range(DIR_UNUSED_LO, DIR_UNUSED_HI))
                         : 3'($urandom_range(abr_pkg::PORT_LOCAL, abr_pkg::PORT_YM));
            h.in_ch    = 2'($urandom_range(0, 3));
            h.bubble   = 8'($urandom_range(0, 255));
            h.rnd      = 3'($urandom_range(0, 7));
            hdr_queue.push_back(h);
        end
    endtask

    // wait until every header is sent and every candidate has come out
    task automatic drain_idle();
        while (hdr_queue.size() != 0 || s_tvalid || expected_cands.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic mis_en, input logic [2:0] local_port);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= abr_pkg::CFG_MISROUTE_EN;
        cfg_wdata <= {2'b00, mis_en};
        @(posedge aclk);
        cfg_index <= abr_pkg::CFG_LOCAL_PORT;
        cfg_wdata <= local_port;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_misroute_en = mis_en;
        cfg_local_port  = local_port;
    endtask

    // header driver: bursts of transfers with random gaps
    always @(posedge aclk) begin : hdr_driver
        logic fire;
        fire = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (fire)
                predict_route(cur_hdr);
            if (!s_tvalid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (hdr_queue.size() > 0) begin
                    cur_hdr = hdr_queue.pop_front();
                    s_tdata  <= pack_header(cur_hdr);
                    s_tuser  <= cur_hdr.is_req;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: changing stall pattern plus long hold-offs to back up the queue
    always @(posedge aclk) begin : result_receiver
        int rx_seen;
        int next_hold_at;
        int hold_left;
        int rx_cycle;
        int rx_mode;
        if (!aresetn) begin
            rx_seen = 0;
            next_hold_at = 50;
            hold_left = 0;
            rx_cycle = 0;
            rx_mode = 0;
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (m_tvalid && m_tready)
                rx_seen++;
            if (rx_cycle % 32 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left == 0 && rx_seen >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 350;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    // result checker: each transfer against the oldest expected candidate
    always @(posedge aclk) begin : result_monitor
        cand_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cands.size() == 0) begin
                report_mismatch("result with none pending, m_tdata", m_tdata, 0);
            end else begin
                want = expected_cands.pop_front();
                if (m_tdata[2:0] !== want.port)
                    report_mismatch("out_port", m_tdata[2:0], want.port);
                if (m_tdata[5:3] !== want.chan)
                    report_mismatch("out_channel", m_tdata[5:3], want.chan);
                if (m_tuser[abr_pkg::M_TUSER_EMPTY] !== want.empty)
                    report_mismatch("list_empty", m_tuser[abr_pkg::M_TUSER_EMPTY],
                                    want.empty);
                if (m_tuser[abr_pkg::M_TUSER_ERROR] !== want.err)
                    report_mismatch("route_error", m_tuser[abr_pkg::M_TUSER_ERROR],
                                    want.err);
                if (m_tlast !== want.last)
                    report_mismatch("last_result", m_tlast, want.last);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin : idle_watchdog
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("** bubble_adaptive_route_compute_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold one, highest consumer index
        write_config(1'b0, 3'd7);
        // arrival on the threshold
        hdr_queue.push_back(mk_header(1, -1, 0, 0, 0, 0, abr_pkg::PORT_LOCAL, 0, 8'h00, 3'd0));
        // zero offsets below the threshold: both misroute pairs
        hdr_queue.push_back(mk_header(0, 0, 1, 1, 1, 0, abr_pkg::PORT_LOCAL, 0, 8'h00, 3'd6));
        // extremes from local, adaptive pair plus dor
        hdr_queue.push_back(mk_header(32, -32, 0, 0, 1, 0, abr_pkg::PORT_LOCAL, 0, 8'hff,
                                      3'd1));
        // straight on in x- without bubble
        hdr_queue.push_back(mk_header(-32, 32, 0, 0, 0, 0, abr_pkg::PORT_XM, 0, 8'h00, 3'd0));
        // forbidden turn into x from y
        hdr_queue.push_back(mk_header(5, 0, 0, 0, 1, 0, abr_pkg::PORT_YP, 2, 8'hff, 3'd0));
        // forbidden reversal in x
        hdr_queue.push_back(mk_header(-3, 0, 0, 0, 0, 0, abr_pkg::PORT_XP, 3, 8'hff, 3'd0));
        // turn into y, bubble missing then present
        hdr_queue.push_back(mk_header(1, 4, 0, 0, 1, 0, abr_pkg::PORT_XP, 0, 8'hfb, 3'd0));
        hdr_queue.push_back(mk_header(1, 4, 0, 0, 1, 0, abr_pkg::PORT_XP, 0, 8'h04, 3'd0));
        // empty list
        hdr_queue.push_back(mk_header(0, 1, 0, 0, 0, 0, abr_pkg::PORT_LOCAL, 0, 8'hff, 3'd7));
        // direction-based order: from y, x first
        hdr_queue.push_back(mk_header(3, 3, 0, 0, 0, 1, abr_pkg::PORT_YM, 1, 8'h10, 3'd0));
        // direction-based order: from x, y first, bubble missing
        hdr_queue.push_back(mk_header(-2, -2, 0, 0, 1, 1, abr_pkg::PORT_XP, 1, 8'h00, 3'd1));
        // unknown directions
        hdr_queue.push_back(mk_header(4, 0, 0, 1, 1, 0, DIR_UNUSED_LO, 0, 8'hff, 3'd2));
        hdr_queue.push_back(mk_header(1, -5, 0, 0, 1, 0, DIR_UNUSED_HI, 2, 8'hff, 3'd0));
        hdr_queue.push_back(mk_header(0, 3, 1, 0, 0, 0, DIR_UNUSED_HI - 3'd1, 0, 8'hff, 3'd4));
        // from y: x misroute pair before y pair
        hdr_queue.push_back(mk_header(0, 0, 1, 1, 0, 0, abr_pkg::PORT_YP, 0, 8'h00, 3'd0));
        // flag, channel, bubble and random bits high, offsets on the threshold, still arrival
        hdr_queue.push_back(mk_header(-1, 1, 1, 1, 1, 1, abr_pkg::PORT_YM, 3, 8'hff, 3'd7));
        // adaptive x, dor dropped, y misroute pair
        hdr_queue.push_back(mk_header(2, 0, 0, 1, 1, 0, abr_pkg::PORT_LOCAL, 0, 8'h00, 3'd0));
        hdr_queue.push_back(mk_header(31, -31, 0, 0, 0, 0, abr_pkg::PORT_XP, 2, 8'h00, 3'd5));
        add_random(50);
        drain_idle();

        // threshold zero, consumer index zero
        write_config(1'b1, 3'd0);
        hdr_queue.push_back(mk_header(0, 0, 1, 1, 1, 1, abr_pkg::PORT_XP, 0, 8'hff, 3'd7));
        hdr_queue.push_back(mk_header(0, 1, 1, 0, 1, 0, abr_pkg::PORT_LOCAL, 0, 8'h04, 3'd4));
        hdr_queue.push_back(mk_header(1, 0, 0, 0, 0, 0, abr_pkg::PORT_YM, 0, 8'hff, 3'd0));
        hdr_queue.push_back(mk_header(0, -1, 0, 1, 1, 0, abr_pkg::PORT_XM, 3, 8'h00, 3'd0));
        add_random(55);
        drain_idle();

        write_config(1'b1, 3'd7);
        add_random(50);
        drain_idle();

        write_config(1'b0, 3'd3);
        add_random(50);
        drain_idle();

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("** bubble_adaptive_route_compute_unit: PASSED **");
        else
            $display("** bubble_adaptive_route_compute_unit: FAILED **");
        $finish;
    end

endmodule
